// File: hdl/ietp_pkg.sv
// ----------------------------------------------------------------------------
// ietp_pkg
// Shared types, constants and text tables of the event text line parser.
// ----------------------------------------------------------------------------
package ietp_pkg;

	localparam int SECONDS_BITS = 32;
	localparam int SECX_W       = SECONDS_BITS + 4;
	localparam int NUM_W        = 32;
	localparam int NUMX_W       = NUM_W + 4;
	localparam int MICROS_W     = 20;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int HEAD_LEN     = 12;
	localparam int FRAC_MAX     = 6;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		FLD_TYPE  = 2'd0,
		FLD_CODE  = 2'd1,
		FLD_VALUE = 2'd2
	} fld_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       is_dig;
		logic [3:0] dig;
		logic       is_space;
		logic       is_tab;
		logic       is_comma;
		logic       is_minus;
		logic       is_dot;
	} token_t;

	typedef struct packed {
		logic                ok;
		logic                time_negative;
		logic [31:0]         time_seconds;
		logic [MICROS_W-1:0] time_micros;
		logic [15:0]         event_type;
		logic [15:0]         event_code;
		logic [31:0]         event_value;
	} result_t;

	function automatic logic [7:0] head_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h45;
			4'd1:    c = 8'h76;
			4'd2:    c = 8'h65;
			4'd3:    c = 8'h6E;
			4'd4:    c = 8'h74;
			4'd5:    c = 8'h3A;
			4'd6:    c = 8'h20;
			4'd7:    c = 8'h74;
			4'd8:    c = 8'h69;
			4'd9:    c = 8'h6D;
			4'd10:   c = 8'h65;
			4'd11:   c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] label_char(input fld_t fld, input logic [3:0] pos);
		logic [7:0] c;
		c = 8'h00;
		unique case (fld)
			FLD_TYPE: begin
				unique case (pos)
					4'd0:    c = 8'h74;
					4'd1:    c = 8'h79;
					4'd2:    c = 8'h70;
					4'd3:    c = 8'h65;
					4'd4:    c = 8'h20;
					default: c = 8'h00;
				endcase
			end
			FLD_CODE: begin
				unique case (pos)
					4'd0:    c = 8'h63;
					4'd1:    c = 8'h6F;
					4'd2:    c = 8'h64;
					4'd3:    c = 8'h65;
					4'd4:    c = 8'h20;
					default: c = 8'h00;
				endcase
			end
			FLD_VALUE: begin
				unique case (pos)
					4'd0:    c = 8'h76;
					4'd1:    c = 8'h61;
					4'd2:    c = 8'h6C;
					4'd3:    c = 8'h75;
					4'd4:    c = 8'h65;
					4'd5:    c = 8'h20;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] label_len(input fld_t fld);
		return (fld == FLD_VALUE) ? 4'd6 : 4'd5;
	endfunction

	// weight of the next fraction digit in microseconds
	function automatic logic [16:0] frac_weight(input logic [2:0] frac);
		logic [16:0] w;
		unique case (frac)
			3'd0:    w = 17'd100000;
			3'd1:    w = 17'd10000;
			3'd2:    w = 17'd1000;
			3'd3:    w = 17'd100;
			3'd4:    w = 17'd10;
			3'd5:    w = 17'd1;
			default: w = 17'd0;
		endcase
		return w;
	endfunction

endpackage

// File: hdl/ietp_front.sv
// ----------------------------------------------------------------------------
// ietp_front
// Input side: accepts characters and classifies them into tokens.
// ----------------------------------------------------------------------------
module ietp_front import ietp_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last,
	input  logic       q_full,
	output logic       push,
	output token_t     tok
);

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		tok.ch       = ch;
		tok.last     = last;
		tok.is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
		tok.dig      = ch[3:0];
		tok.is_space = (ch == CH_SPACE);
		tok.is_tab   = (ch == CH_TAB);
		tok.is_comma = (ch == CH_COMMA);
		tok.is_minus = (ch == CH_MINUS);
		tok.is_dot   = (ch == CH_DOT);
	end

endmodule

// File: hdl/ietp_queue.sv
// ----------------------------------------------------------------------------
// ietp_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module ietp_queue import ietp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  token_t push_tok,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output token_t head_tok
);

	token_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_tok   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/ietp_back.sv
// ----------------------------------------------------------------------------
// ietp_back
// Parser: walks the line one token per cycle unless the result stalls it, and registers the result.
// ----------------------------------------------------------------------------
module ietp_back import ietp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    tok_valid,
	input  token_t  tok,
	output logic    pop,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	typedef enum logic [11:0] {
		PH_LEAD   = 12'b0000_0000_0001,
		PH_PREFIX = 12'b0000_0000_0010,
		PH_TSIGN  = 12'b0000_0000_0100,
		PH_TINT   = 12'b0000_0000_1000,
		PH_TFRAC  = 12'b0000_0001_0000,
		PH_SKIP   = 12'b0000_0010_0000,
		PH_FSP    = 12'b0000_0100_0000,
		PH_LABEL  = 12'b0000_1000_0000,
		PH_NSIGN  = 12'b0001_0000_0000,
		PH_NDIG   = 12'b0010_0000_0000,
		PH_DONE   = 12'b0100_0000_0000,
		PH_DEAD   = 12'b1000_0000_0000
	} phase_t;

	phase_t                  phase_q, n_phase;
	logic [3:0]              pos_q, n_pos;
	logic                    failed_q, n_failed;
	logic                    neg_q, n_neg;
	logic                    tneg_q, n_tneg;
	logic                    dseen_q, n_dseen;
	logic [2:0]              frac_q, n_frac;
	logic [SECONDS_BITS-1:0] sec_q, n_sec;
	logic [MICROS_W-1:0]     mic_q, n_mic;
	logic [NUM_W-1:0]        num_q, n_num;
	logic [15:0]             type_q, n_type;
	logic [15:0]             code_q, n_code;
	logic [31:0]             val_q, n_val;
	fld_t                    fld_q, n_fld;

	logic                    res_valid_q;
	result_t                 res_q;

	logic                    fail_c;
	logic [SECX_W-1:0]       sec_x;
	logic [NUMX_W-1:0]       num_x;
	logic [NUMX_W-1:0]       num_lim;
	logic [20:0]             mic_add;
	logic [7:0]              lab_c;
	logic [3:0]              pos_inc;
	logic                    fin_now;
	logic                    good;

	assign pop       = tok_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign sec_x   = (SECX_W'(sec_q) << 3) + (SECX_W'(sec_q) << 1) + SECX_W'(tok.dig);
	assign num_x   = (NUMX_W'(num_q) << 3) + (NUMX_W'(num_q) << 1) + NUMX_W'(tok.dig);
	assign num_lim = (fld_q != FLD_VALUE) ? NUMX_W'(65535) :
	                 neg_q ? NUMX_W'(64'h8000_0000) : NUMX_W'(64'h7FFF_FFFF);
	assign mic_add = 21'(tok.dig) * 21'(frac_weight(frac_q));
	assign lab_c   = label_char(fld_q, pos_q);
	assign pos_inc = pos_q + 1'b1;

	always_comb begin
		n_phase  = phase_q;
		n_pos    = pos_q;
		n_failed = failed_q;
		n_neg    = neg_q;
		n_tneg   = tneg_q;
		n_dseen  = dseen_q;
		n_frac   = frac_q;
		n_sec    = sec_q;
		n_mic    = mic_q;
		n_num    = num_q;
		n_type   = type_q;
		n_code   = code_q;
		n_val    = val_q;
		n_fld    = fld_q;
		fail_c   = 1'b0;

		unique case (phase_q)
			PH_LEAD: begin
				if (!tok.is_space && !tok.is_tab) begin
					if (tok.ch == head_char(4'd0)) begin
						n_phase = PH_PREFIX;
						n_pos   = 4'd1;
					end else begin
						fail_c = 1'b1;
					end
				end
			end
			PH_PREFIX: begin
				if (pos_q >= 4'(HEAD_LEN) || tok.ch != head_char(pos_q)) begin
					fail_c = 1'b1;
				end else begin
					n_pos = pos_inc;
					if (pos_inc == 4'(HEAD_LEN)) begin
						n_phase = PH_TSIGN;
					end
				end
			end
			PH_TSIGN, PH_TINT: begin
				if (tok.is_minus && phase_q == PH_TSIGN) begin
					n_tneg  = 1'b1;
					n_phase = PH_TINT;
				end else if (tok.is_dig) begin
					n_dseen = 1'b1;
					n_phase = PH_TINT;
					n_sec   = (sec_x > SECX_W'({SECONDS_BITS{1'b1}})) ? {SECONDS_BITS{1'b1}}
					                                                : SECONDS_BITS'(sec_x);
				end else if (tok.is_dot) begin
					n_phase = PH_TFRAC;
				end else if (phase_q == PH_TSIGN || !dseen_q) begin
					fail_c = 1'b1;
				end else begin
					n_phase = tok.is_comma ? PH_FSP : PH_SKIP;
				end
			end
			PH_TFRAC: begin
				if (tok.is_dig) begin
					n_dseen = 1'b1;
					if (frac_q < 3'(FRAC_MAX)) begin
						n_mic  = MICROS_W'(21'(mic_q) + mic_add);
						n_frac = frac_q + 1'b1;
					end
				end else if (!dseen_q) begin
					fail_c = 1'b1;
				end else begin
					n_phase = tok.is_comma ? PH_FSP : PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (tok.is_comma) begin
					n_phase = PH_FSP;
				end
			end
			PH_FSP: begin
				if (!tok.is_space) begin
					n_phase = PH_LABEL;
					n_pos   = 4'd0;
					if (tok.ch != label_char(fld_q, 4'd0)) begin
						fail_c = 1'b1;
					end else begin
						n_pos = 4'd1;
					end
				end
			end
			PH_LABEL: begin
				if (tok.ch != lab_c) begin
					fail_c = 1'b1;
				end else begin
					n_pos = pos_inc;
					if (pos_inc >= label_len(fld_q)) begin
						n_phase = PH_NSIGN;
						n_num   = '0;
						n_neg   = 1'b0;
						n_dseen = 1'b0;
					end
				end
			end
			PH_NSIGN, PH_NDIG: begin
				if (tok.is_dig) begin
					n_phase = PH_NDIG;
					n_dseen = 1'b1;
					if (num_x > num_lim) begin
						fail_c = 1'b1;
					end else begin
						n_num = NUM_W'(num_x);
					end
				end else if (phase_q == PH_NSIGN) begin
					if (tok.is_minus && fld_q == FLD_VALUE) begin
						n_neg   = 1'b1;
						n_phase = PH_NDIG;
					end else begin
						fail_c = 1'b1;
					end
				end else if (!dseen_q) begin
					fail_c = 1'b1;
				end else begin
					unique case (fld_q)
						FLD_TYPE: begin
							n_type  = num_q[15:0];
							n_fld   = FLD_CODE;
							n_phase = tok.is_comma ? PH_FSP : PH_SKIP;
						end
						FLD_CODE: begin
							n_code  = num_q[15:0];
							n_fld   = FLD_VALUE;
							n_phase = tok.is_comma ? PH_FSP : PH_SKIP;
						end
						default: begin
							n_val   = neg_q ? 32'(0 - num_q) : num_q;
							n_phase = PH_DONE;
						end
					endcase
				end
			end
			PH_DONE, PH_DEAD: begin
			end
			default: begin
				fail_c = 1'b1;
			end
		endcase

		if (fail_c) begin
			n_failed = 1'b1;
			n_phase  = PH_DEAD;
		end
	end

	assign fin_now = (n_phase == PH_NDIG) && (n_fld == FLD_VALUE) && n_dseen;
	assign good    = !n_failed && ((n_phase == PH_DONE) || fin_now);

	always_ff @(posedge clk) begin
		if (pop && tok.last) begin
			res_q.ok            <= good;
			res_q.time_negative <= good && n_tneg;
			res_q.time_seconds  <= good ? 32'(n_sec) : '0;
			res_q.time_micros   <= good ? n_mic : '0;
			res_q.event_type    <= good ? n_type : '0;
			res_q.event_code    <= good ? n_code : '0;
			if (!good) begin
				res_q.event_value <= '0;
			end else if (fin_now) begin
				res_q.event_value <= n_neg ? 32'(0 - n_num) : n_num;
			end else begin
				res_q.event_value <= n_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && tok.last) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			pos_q    <= '0;
			failed_q <= 1'b0;
			neg_q    <= 1'b0;
			tneg_q   <= 1'b0;
			dseen_q  <= 1'b0;
			frac_q   <= '0;
			sec_q    <= '0;
			mic_q    <= '0;
			num_q    <= '0;
			type_q   <= '0;
			code_q   <= '0;
			val_q    <= '0;
			fld_q    <= FLD_TYPE;
		end else if (pop && tok.last) begin
			phase_q  <= PH_LEAD;
			pos_q    <= '0;
			failed_q <= 1'b0;
			neg_q    <= 1'b0;
			tneg_q   <= 1'b0;
			dseen_q  <= 1'b0;
			frac_q   <= '0;
			sec_q    <= '0;
			mic_q    <= '0;
			num_q    <= '0;
			type_q   <= '0;
			code_q   <= '0;
			val_q    <= '0;
			fld_q    <= FLD_TYPE;
		end else if (pop) begin
			phase_q  <= n_phase;
			pos_q    <= n_pos;
			failed_q <= n_failed;
			neg_q    <= n_neg;
			tneg_q   <= n_tneg;
			dseen_q  <= n_dseen;
			frac_q   <= n_frac;
			sec_q    <= n_sec;
			mic_q    <= n_mic;
			num_q    <= n_num;
			type_q   <= n_type;
			code_q   <= n_code;
			val_q    <= n_val;
			fld_q    <= n_fld;
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!res_valid_q || res_ready))
		else $error("token popped while result slot is blocked");

	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && tok.last) |=> (phase_q == PH_LEAD && !failed_q && fld_q == FLD_TYPE))
		else $error("parser state not cleared after line end");

	a_fail_is_dead: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> (phase_q == PH_DEAD))
		else $error("failed line left the dead phase");

	a_bad_line_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.ok) |-> (res_q.time_seconds == '0 && res_q.time_micros == '0
			&& res_q.event_type == '0 && res_q.event_code == '0
			&& res_q.event_value == '0 && !res_q.time_negative))
		else $error("failed line result carries nonzero fields");

	a_micros_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.time_micros < MICROS_W'(1000000)))
		else $error("microseconds out of range");
`endif

endmodule

// File: hdl/input_event_text_line_parser.sv
// ----------------------------------------------------------------------------
// input_event_text_line_parser
// Parses event text lines, one character per cycle while in_ready, into time and event fields.
// ----------------------------------------------------------------------------
// Characters are taken at one per cycle while in_ready is high, with no gaps
// between lines. A classifier writes each character into a four-entry token
// queue; the parser drains it at one token per cycle, while no result waits
// on out_ready, into a single result register, which takes a line's result
// when the parser pops that line's last token. A result waiting on out_ready
// stalls the parser only; input keeps flowing until the queue holds four
// tokens. Every line gives one result on its last character; ok low means
// the line did not parse, and then all other result fields are zero.
module input_event_text_line_parser import ietp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic        time_negative,
	output logic [31:0] time_seconds,
	output logic [19:0] time_micros,
	output logic [15:0] event_type,
	output logic [15:0] event_code,
	output logic signed [31:0] event_value
);

	logic    q_full;
	logic    push;
	token_t  push_tok;
	logic    head_valid;
	token_t  head_tok;
	logic    pop;
	result_t res;

	ietp_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.last     (last),
		.q_full   (q_full),
		.push     (push),
		.tok      (push_tok)
	);

	ietp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (push_tok),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_tok   (head_tok)
	);

	ietp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (head_valid),
		.tok       (head_tok),
		.pop       (pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign ok            = res.ok;
	assign time_negative = res.time_negative;
	assign time_seconds  = res.time_seconds;
	assign time_micros   = res.time_micros;
	assign event_type    = res.event_type;
	assign event_code    = res.event_code;
	assign event_value   = res.event_value;

endmodule

// File: dv/ietp_line_check_pkg.sv
// ----------------------------------------------------------------------------
// ietp_line_check_pkg
// Line predictor and result scoreboard for the event text line parser bench.
// Each accepted character advances a parse of the current line; the final
// character of a line yields the result the block must give for that line.
// ----------------------------------------------------------------------------
package ietp_line_check_pkg;
	import ietp_pkg::*;

	localparam string HEAD_TEXT = "Event: time ";
	localparam longint unsigned SECONDS_MAX = (64'd1 << SECONDS_BITS) - 64'd1;
	localparam int REPORT_LIMIT = 100;

	typedef enum logic [3:0] {
		P_LEAD, P_PREFIX, P_TSIGN, P_TINT, P_TFRAC, P_SKIP,
		P_FSP, P_LABEL, P_NSIGN, P_NDIG, P_DONE, P_DEAD
	} line_phase_e;

	class event_line_checker;
		line_phase_e     phase;
		int unsigned     match_pos;
		int unsigned     frac_cnt;
		bit              dead;
		bit              num_neg;
		bit              time_neg;
		bit              saw_digit;
		longint unsigned sec_acc;
		longint unsigned num_acc;
		int unsigned     micro_acc;
		bit [15:0]       type_q;
		bit [15:0]       code_q;
		bit [31:0]       value_q;
		fld_t            field;
		result_t         due_results[$];
		int              errors;
		int              chars_taken;
		int              lines_seen;
		int              lines_parsed;
		int              results_checked;

		function new();
			errors = 0;
			chars_taken = 0;
			lines_seen = 0;
			lines_parsed = 0;
			results_checked = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase = P_LEAD;
			match_pos = 0;
			frac_cnt = 0;
			dead = 1'b0;
			num_neg = 1'b0;
			time_neg = 1'b0;
			saw_digit = 1'b0;
			sec_acc = 0;
			num_acc = 0;
			micro_acc = 0;
			type_q = '0;
			code_q = '0;
			value_q = '0;
			field = FLD_TYPE;
		endfunction

		function void drop_line();
			dead = 1'b1;
			phase = P_DEAD;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		function string label_text();
			case (field)
				FLD_TYPE: return "type ";
				FLD_CODE: return "code ";
				default:  return "value ";
			endcase
		endfunction

		function void add_second(int unsigned d);
			if (sec_acc > (SECONDS_MAX - d) / 10) sec_acc = SECONDS_MAX;
			else sec_acc = sec_acc * 10 + d;
		endfunction

		function void add_digit(int unsigned d);
			longint unsigned t;
			longint unsigned lim;
			t = num_acc * 10 + d;
			saw_digit = 1'b1;
			if (field != FLD_VALUE) lim = 65535;
			else lim = num_neg ? 64'd2147483648 : 64'd2147483647;
			if (t > lim) drop_line();
			else num_acc = t;
		endfunction

		function void skip_to_comma(logic [7:0] c);
			if (c == CH_COMMA) phase = P_FSP;
		endfunction

		function void close_number(logic [7:0] c);
			case (field)
				FLD_TYPE: begin
					type_q = num_acc[15:0];
					field = FLD_CODE;
				end
				FLD_CODE: begin
					code_q = num_acc[15:0];
					field = FLD_VALUE;
				end
				default: begin
					value_q = num_neg ? 32'd0 - num_acc[31:0] : num_acc[31:0];
					phase = P_DONE;
					return;
				end
			endcase
			phase = P_SKIP;
			skip_to_comma(c);
		endfunction

		function void match_head(logic [7:0] c);
			if (match_pos >= HEAD_LEN || c != HEAD_TEXT[match_pos]) begin
				drop_line();
				return;
			end
			match_pos++;
			if (match_pos == HEAD_LEN) phase = P_TSIGN;
		endfunction

		function void parse_char(logic [7:0] c);
			string lab;
			case (phase)
				P_LEAD: begin
					if (c != CH_SPACE && c != CH_TAB) begin
						phase = P_PREFIX;
						match_pos = 0;
						match_head(c);
					end
				end
				P_PREFIX: match_head(c);
				P_TSIGN: begin
					if (c == CH_MINUS) begin
						time_neg = 1'b1;
						phase = P_TINT;
					end else if (is_digit(c)) begin
						saw_digit = 1'b1;
						add_second(c - CH_ZERO);
						phase = P_TINT;
					end else if (c == CH_DOT) begin
						phase = P_TFRAC;
					end else begin
						drop_line();
					end
				end
				P_TINT: begin
					if (is_digit(c)) begin
						saw_digit = 1'b1;
						add_second(c - CH_ZERO);
					end else if (c == CH_DOT) begin
						phase = P_TFRAC;
					end else if (!saw_digit) begin
						drop_line();
					end else begin
						phase = P_SKIP;
						skip_to_comma(c);
					end
				end
				P_TFRAC: begin
					if (is_digit(c)) begin
						saw_digit = 1'b1;
						if (frac_cnt < FRAC_MAX) begin
							micro_acc = micro_acc * 10 + (c - CH_ZERO);
							frac_cnt++;
						end
					end else if (!saw_digit) begin
						drop_line();
					end else begin
						phase = P_SKIP;
						skip_to_comma(c);
					end
				end
				P_SKIP: skip_to_comma(c);
				P_FSP: begin
					if (c != CH_SPACE) begin
						lab = label_text();
						phase = P_LABEL;
						match_pos = 1;
						if (c != lab[0]) drop_line();
					end
				end
				P_LABEL: begin
					lab = label_text();
					if (c != lab[match_pos]) begin
						drop_line();
					end else begin
						match_pos++;
						if (match_pos >= lab.len()) begin
							phase = P_NSIGN;
							num_acc = 0;
							num_neg = 1'b0;
							saw_digit = 1'b0;
						end
					end
				end
				P_NSIGN: begin
					if (is_digit(c)) begin
						phase = P_NDIG;
						add_digit(c - CH_ZERO);
					end else if (c == CH_MINUS && field == FLD_VALUE) begin
						num_neg = 1'b1;
						phase = P_NDIG;
					end else begin
						drop_line();
					end
				end
				P_NDIG: begin
					if (is_digit(c)) add_digit(c - CH_ZERO);
					else if (!saw_digit) drop_line();
					else close_number(c);
				end
				default: ;
			endcase
		endfunction

		function void take_char(logic [7:0] c, logic fin);
			result_t     due;
			int unsigned mic;
			int unsigned k;
			chars_taken++;
			parse_char(c);
			if (!fin) return;
			if (!dead && phase == P_NDIG && field == FLD_VALUE && saw_digit)
				close_number(CH_COMMA);
			due = '0;
			if (!dead && phase == P_DONE) begin
				mic = micro_acc;
				for (k = frac_cnt; k < FRAC_MAX; k++) mic = mic * 10;
				due.ok = 1'b1;
				due.time_negative = time_neg;
				due.time_seconds = sec_acc[31:0];
				due.time_micros = mic[MICROS_W-1:0];
				due.event_type = type_q;
				due.event_code = code_q;
				due.event_value = value_q;
				lines_parsed++;
			end
			lines_seen++;
			due_results.push_back(due);
			clear_line();
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= REPORT_LIMIT)
				$display("MISMATCH result %0d: %s", results_checked, msg);
		endtask

		task check_field(string name, longint unsigned got, longint unsigned want);
			if (got != want)
				report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check_line_result(result_t got);
			result_t want;
			results_checked++;
			if (due_results.size() == 0) begin
				report("result with no line pending");
				return;
			end
			want = due_results.pop_front();
			check_field("ok", got.ok, want.ok);
			check_field("time_negative", got.time_negative, want.time_negative);
			check_field("time_seconds", got.time_seconds, want.time_seconds);
			check_field("time_micros", got.time_micros, want.time_micros);
			check_field("event_type", got.event_type, want.event_type);
			check_field("event_code", got.event_code, want.event_code);
			check_field("event_value", got.event_value, want.event_value);
		endtask
	endclass

endpackage

// File: dv/input_event_text_line_parser_test.sv
// ----------------------------------------------------------------------------
// input_event_text_line_parser_test
// Feeds text lines one character per beat: hand-written lines for the edge
// cases, then random event lines, some broken, plus raw noise. Every result
// beat is checked field by field against the line predictor, with random
// idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module input_event_text_line_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ietp_pkg::*;
	import ietp_line_check_pkg::*;

	localparam int TOTAL_CHARS  = 1100;
	localparam int RANDOM_LINES = 2;
	localparam int IDLE_PCT     = 13;
	localparam int NOIDLE_FROM  = 600;
	localparam int NOIDLE_TO    = 900;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 20;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         ch;
	logic               last;
	logic               out_valid;
	logic               out_ready;
	logic               ok;
	logic               time_negative;
	logic [31:0]        time_seconds;
	logic [19:0]        time_micros;
	logic [15:0]        event_type;
	logic [15:0]        event_code;
	logic signed [31:0] event_value;
	logic               stall_hold;

	logic [8:0]         beats[$];
	byte unsigned       line_buf[$];
	int                 random_lines = 0;
	event_line_checker  board = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	input_event_text_line_parser i_dut (.*);

	function automatic void put_text(string s);
		int i;
		for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic void put_digits(int n);
		repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void put_num(longint v);
		put_text($sformatf("%0d", v));
	endfunction

	function automatic void put_note();
		byte unsigned b;
		if ($urandom_range(0, 2) != 0) return;
		line_buf.push_back(CH_SPACE);
		repeat ($urandom_range(1, 4)) begin
			b = 8'($urandom_range(8'h21, 8'h7E));
			line_buf.push_back(b == CH_COMMA ? CH_DOT : b);
		end
	endfunction

	function automatic void put_sep();
		repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
		line_buf.push_back(CH_COMMA);
		repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
	endfunction

	function automatic longint pick_u16();
		case ($urandom_range(0, 19))
			0:       return 0;
			1:       return 65535;
			2:       return 65536 + $urandom_range(0, 40000);
			3, 4, 5: return $urandom_range(0, 9);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic longint pick_s32();
		case ($urandom_range(0, 19))
			0:       return 64'sd2147483647;
			1:       return -64'sd2147483648;
			2:       return 64'sd2147483648;
			3:       return -64'sd2147483649;
			4, 5, 6: return longint'($urandom_range(0, 200)) - 100;
			default: return longint'(int'($urandom()));
		endcase
	endfunction

	function automatic void make_event_line();
		int int_len;
		repeat ($urandom_range(0, 3))
			line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		put_text("Event: time ");
		if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_MINUS);
		case ($urandom_range(0, 9))
			0:       int_len = 0;
			1, 2:    int_len = $urandom_range(6, 13);
			default: int_len = $urandom_range(1, 5);
		endcase
		put_digits(int_len);
		if (int_len == 0 || $urandom_range(0, 2) != 0) begin
			line_buf.push_back(CH_DOT);
			put_digits($urandom_range(int_len == 0 ? 1 : 0, 9));
		end
		put_note();
		put_sep();
		put_text("type ");
		put_num(pick_u16());
		put_note();
		put_sep();
		put_text("code ");
		put_num(pick_u16());
		put_note();
		put_sep();
		put_text("value ");
		put_num(pick_s32());
		put_note();
	endfunction

	function automatic void break_line();
		int k;
		k = $urandom_range(0, line_buf.size() - 1);
		case ($urandom_range(0, 2))
			0: line_buf[k] = 8'($urandom_range(0, 255));
			1: while (line_buf.size() > k + 1) void'(line_buf.pop_back());
			default: if (line_buf.size() > 1) line_buf.delete(k);
		endcase
	endfunction

	function automatic void end_line();
		if (line_buf.size() == 0) line_buf.push_back(8'($urandom_range(0, 255)));
		foreach (line_buf[i])
			beats.push_back({(i == line_buf.size() - 1) ? 1'b1 : 1'b0, 8'(line_buf[i])});
		line_buf.delete();
	endfunction

	function automatic void build_directed();
		string lines[$];
		lines = '{
			"Event: time 1700000000.123456, type 1, code 330, value 1",
			" \t  Event: time 0.000001, type 0, code 0, value 0",
			"Event: time 4294967295.999999, type 65535, code 65535, value 2147483647",
			"Event: time 99999999999.5, type 3, code 0, value -2147483648",
			"Event: time 4294967296, type 3, code 4, value 5",
			"Event: time 1.1234567 s, type 2 (x), code 3 [y], value 4 tail, text",
			"Event: time 5, type 65536, code 1, value 1",
			"Event: time 5, type 1, code 65536, value 1",
			"Event: time 5, type 1, code 1, value 2147483648",
			"Event: time 5, type 1, code 1, value -2147483649",
			"Event: time -0, type 1, code 2, value -5",
			"Event: time .5,type 1,code 2,value 3",
			"Event: time 5., type 1, code 2, value 3",
			"Event: time -, type 1, code 1, value 1",
			"Event: time 12 type 1 code 1 value 1",
			"Event: time  12, type 1, code 1, value 1",
			"Event: time 12,\ttype 1, code 1, value 1",
			"Event: time inf, type 1, code 1, value 1",
			"Event: time nan, type 1, code 1, value 1",
			"Event: time +3, type 1, code 1, value 1",
			"Event: time 3, type 1, code 1, value +1",
			"Event: time 3, type 1, code 1, value -",
			"Event: time 3, type -1, code 1, value 1",
			"Event: time 3, kind 1, code 1, value 1",
			"Event: time 3, type 1, code 1",
			"Event: time 007.000, type 00065535, code 0, value -0",
			"E"
		};
		foreach (lines[i]) begin
			put_text(lines[i]);
			end_line();
		end
	endfunction

	function automatic void build_random();
		while (beats.size() < TOTAL_CHARS || random_lines < RANDOM_LINES) begin
			case ($urandom_range(0, 19))
				0, 1: repeat ($urandom_range(1, 10))
					line_buf.push_back(8'($urandom_range(0, 255)));
				2, 3, 4: begin
					make_event_line();
					break_line();
				end
				default: make_event_line();
			endcase
			end_line();
			random_lines++;
		end
	endfunction

	task automatic drive_chars();
		int offer_idx;
		offer_idx = 0;
		forever begin
			@(posedge clk);
			if (in_valid && in_ready) board.take_char(ch, last);
			else if (in_valid) continue;
			if (offer_idx >= beats.size()) begin
				in_valid <= 1'b0;
				break;
			end
			if ($urandom_range(0, 99) < IDLE_PCT &&
			    !(board.chars_taken >= NOIDLE_FROM && board.chars_taken < NOIDLE_TO)) begin
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				{last, ch} <= beats[offer_idx];
				offer_idx++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		ch <= '0;
		last <= 1'b0;
		build_directed();
		build_random();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		drive_chars();
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d lines in %0d characters: %0d parsed, %0d rejected.",
			board.lines_seen, board.chars_taken, board.lines_parsed,
			board.lines_seen - board.lines_parsed);
		$display("Receiver held off %0d cycles once; %0d field mismatches.",
			HOLD_CYCLES, board.errors);
		if (board.errors == 0) begin
			$display("input_event_text_line_parser test passed");
		end else begin
			$display("input_event_text_line_parser test failed");
		end
		$finish;
	end

	initial begin
		result_t seen;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen.ok = ok;
				seen.time_negative = time_negative;
				seen.time_seconds = time_seconds;
				seen.time_micros = time_micros;
				seen.event_type = event_type;
				seen.event_code = event_code;
				seen.event_value = event_value;
				board.check_line_result(seen);
			end
			if (stall_hold)
				out_ready <= 1'b0;
			else if (board.results_checked >= 10 && board.results_checked < 30)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		stall_hold <= 1'b0;
		@(posedge arst_n);
		while (board.chars_taken < HOLD_AFTER) @(posedge clk);
		stall_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_hold <= 1'b0;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d results outstanding", board.pending());
		$display("input_event_text_line_parser test failed");
		$finish;
	end

endmodule
